@@ rtl/krpc_pkg.sv @@
// Shared types, constants and enums for the kd-tree radius pair counter.
// No dependencies.
package krpc_pkg;

    localparam int unsigned DIMS_DEF         = 3;
    localparam int unsigned NODE_COUNT_DEF   = 1024;
    localparam int unsigned TREE_FIELDS_DEF  = 8;
    localparam int unsigned QUERY_FIELDS_DEF = 8;
    localparam int unsigned STACK_DEPTH_DEF  = 10;

    localparam int unsigned COORD_W = 24;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned WGT_W   = 16;
    localparam int unsigned FLD_W   = 3;
    localparam int unsigned CNT_W   = 48;
    localparam int unsigned RAD_W   = 23;
    localparam int unsigned INFO_W  = 23;
    localparam int unsigned SQ_W    = 50;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WAIT,
        ST_SQ,
        ST_SUM,
        ST_DECIDE,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_READ,
        ST_OUT,
        ST_CLEAR
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the accepted beat
        logic load_node; // write node memories
        logic fetch;     // read node memories at current index
        logic square;    // register the squared differences
        logic sum;       // compare the distance sum and register the decisions
        logic step;      // advance walk to next node
        logic cnt_rd;    // read counter cell
        logic cnt_wr;    // write counter cell
        logic rd_sel;    // read counter at request row/column
        logic out_load;  // load result register
        logic clr;       // clear one counter cell
        logic clr_start;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic do_count;  // node in radius and counted
        logic walk_done;
        logic clr_done;
    } t_status;

endpackage

@@ rtl/krpc_datapath.sv @@
// Datapath: node memories, distance unit, walk stack and counter memory.
// Depends on krpc_pkg.
module krpc_datapath #(
    parameter int unsigned DIMS         = krpc_pkg::DIMS_DEF,
    parameter int unsigned NODE_COUNT   = krpc_pkg::NODE_COUNT_DEF,
    parameter int unsigned TREE_FIELDS  = krpc_pkg::TREE_FIELDS_DEF,
    parameter int unsigned QUERY_FIELDS = krpc_pkg::QUERY_FIELDS_DEF,
    parameter int unsigned STACK_DEPTH  = krpc_pkg::STACK_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  krpc_pkg::t_cmd                      i_cmd,
    output krpc_pkg::t_status                   o_status,
    input  logic [krpc_pkg::RAD_W-1:0]          i_radius,
    input  logic [krpc_pkg::IDX_W-1:0]          i_node_index,
    input  logic signed [krpc_pkg::COORD_W-1:0] i_coord_0,
    input  logic signed [krpc_pkg::COORD_W-1:0] i_coord_1,
    input  logic signed [krpc_pkg::COORD_W-1:0] i_coord_2,
    input  logic [1:0]                          i_split_axis,
    input  logic                                i_has_left,
    input  logic                                i_has_right,
    input  logic [krpc_pkg::WGT_W-1:0]          i_node_weight,
    input  logic [krpc_pkg::FLD_W-1:0]          i_tree_field,
    input  logic [krpc_pkg::FLD_W-1:0]          i_query_field,
    output logic [krpc_pkg::CNT_W-1:0]          o_count_value
);
    localparam int unsigned NA_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int unsigned CUR_W = NA_W + 1;
    localparam int unsigned CELLS = QUERY_FIELDS * TREE_FIELDS;
    localparam int unsigned CA_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int unsigned SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned SA_W  = $clog2(STACK_DEPTH);
    localparam int unsigned CW    = krpc_pkg::COORD_W;
    localparam int unsigned DW    = CW + 1;
    localparam int unsigned AW    = CW;
    localparam logic [krpc_pkg::CNT_W-1:0] CNT_MAX = '1;

    logic [CW-1:0] r_mem_a [NODE_COUNT];
    logic [CW-1:0] r_mem_b [NODE_COUNT];
    logic [CW-1:0] r_mem_c [NODE_COUNT];
    logic [krpc_pkg::INFO_W-1:0] r_mem_i [NODE_COUNT];
    logic [krpc_pkg::CNT_W-1:0]  r_cnt   [CELLS];
    logic [CUR_W-1:0] r_stack [STACK_DEPTH];

    // Captured request
    logic signed [CW-1:0] r_q0, r_q1, r_q2;
    logic [krpc_pkg::FLD_W-1:0] r_qf, r_tf;
    logic [krpc_pkg::RAD_W-1:0] r_rad;

    // Fetched node
    logic signed [CW-1:0] r_na, r_nb, r_nc;
    logic [krpc_pkg::INFO_W-1:0] r_ni;

    logic [CUR_W-1:0] r_cur;
    logic [SP_W-1:0]  r_sp;
    logic [2*AW-1:0]  r_sq0, r_sq1, r_sq2, r_rsq;
    logic             r_cnt_en, r_go_l, r_go_r, r_done, r_cell_ok;
    logic [CA_W-1:0]  r_cell;
    logic [krpc_pkg::WGT_W-1:0] r_w;
    logic [krpc_pkg::CNT_W-1:0] r_cnt_rd, r_out;
    logic [CA_W:0]    r_clr;

    // Node write
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_node && (32'(i_node_index) < NODE_COUNT)) begin
            r_mem_a[i_node_index[NA_W-1:0]] <= i_coord_0;
            r_mem_b[i_node_index[NA_W-1:0]] <= i_coord_1;
            r_mem_c[i_node_index[NA_W-1:0]] <= i_coord_2;
            r_mem_i[i_node_index[NA_W-1:0]] <= {i_tree_field, i_node_weight,
                                                i_has_right, i_has_left, i_split_axis};
        end
    end

    // Node read, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_na <= r_mem_a[r_cur[NA_W-1:0]];
            r_nb <= r_mem_b[r_cur[NA_W-1:0]];
            r_nc <= r_mem_c[r_cur[NA_W-1:0]];
            r_ni <= r_mem_i[r_cur[NA_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_q0  <= i_coord_0;
            r_q1  <= i_coord_1;
            r_q2  <= i_coord_2;
            r_qf  <= i_query_field;
            r_tf  <= i_tree_field;
            r_rad <= i_radius;
        end
    end

    // Absolute differences and squares
    logic signed [DW-1:0] n_d0, n_d1, n_d2;
    logic [AW-1:0] n_a0, n_a1, n_a2;
    always_comb begin
        n_d0 = DW'(r_na) - DW'(r_q0);
        n_d1 = DW'(r_nb) - DW'(r_q1);
        n_d2 = DW'(r_nc) - DW'(r_q2);
        n_a0 = n_d0[DW-1] ? AW'(-n_d0) : AW'(n_d0);
        n_a1 = n_d1[DW-1] ? AW'(-n_d1) : AW'(n_d1);
        n_a2 = n_d2[DW-1] ? AW'(-n_d2) : AW'(n_d2);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_sq0 <= n_a0 * n_a0;
            r_sq1 <= (DIMS > 1) ? n_a1 * n_a1 : '0;
            r_sq2 <= (DIMS > 2) ? n_a2 * n_a2 : '0;
        end
        if (i_cmd.capture) begin
            r_rsq <= (2*AW)'(i_radius) * (2*AW)'(i_radius);
        end
    end

    // Walk decision
    logic [1:0] n_axis;
    logic n_hl, n_hr;
    logic signed [DW-1:0] n_pt, n_v, n_radx;
    logic n_go_l, n_go_r, n_cnt;
    logic [krpc_pkg::SQ_W-1:0] n_sum;
    logic [CUR_W:0] n_lc, n_rc;
    logic n_qok, n_tok;
    always_comb begin
        n_axis = r_ni[1:0];
        n_hl   = r_ni[2];
        n_hr   = r_ni[3];
        n_radx = DW'(r_rad);
        case (n_axis)
            2'd0:    begin n_pt = DW'(r_na); n_v = DW'(r_q0); end
            2'd1:    begin n_pt = DW'(r_nb); n_v = DW'(r_q1); end
            default: begin n_pt = DW'(r_nc); n_v = DW'(r_q2); end
        endcase
        n_go_l = 1'b0;
        n_go_r = 1'b0;
        n_cnt  = 1'b1;
        if (!n_hl) begin
            n_cnt = 1'b1;
        end else if (!n_hr) begin
            n_go_l = 1'b1;
        end else if (32'(n_axis) < DIMS && n_axis != 2'd3) begin
            if (n_v + n_radx < n_pt) begin
                n_go_l = 1'b1; n_cnt = 1'b0;
            end else if (n_v - n_radx > n_pt) begin
                n_go_r = 1'b1; n_cnt = 1'b0;
            end else begin
                n_go_l = 1'b1; n_go_r = 1'b1;
            end
        end else begin
            n_go_l = 1'b1; n_go_r = 1'b1;
        end
        n_sum = krpc_pkg::SQ_W'(r_sq0) + krpc_pkg::SQ_W'(r_sq1)
              + krpc_pkg::SQ_W'(r_sq2);
        n_lc  = {r_cur, 1'b0};
        n_rc  = {r_cur, 1'b1};
        if (32'(n_lc) >= NODE_COUNT) n_go_l = 1'b0;
        if (32'(n_rc) >= NODE_COUNT) n_go_r = 1'b0;
        n_qok = 32'(r_qf) < QUERY_FIELDS;
        n_tok = 32'(r_ni[22:20]) < TREE_FIELDS;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_cnt_en <= n_cnt && (n_sum < krpc_pkg::SQ_W'(r_rsq)) && n_qok && n_tok;
            r_go_l   <= n_go_l;
            r_go_r   <= n_go_r;
            r_w      <= r_ni[19:4];
            r_cell   <= CA_W'(32'(r_qf) * TREE_FIELDS + 32'(r_ni[22:20]));
        end
    end

    // Walk pointer and stack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp   <= '0;
            r_cur  <= CUR_W'(1);
            r_done <= 1'b0;
        end else if (i_cmd.capture) begin
            r_sp   <= '0;
            r_cur  <= CUR_W'(1);
            r_done <= !(NODE_COUNT > 1);
        end else if (i_cmd.step) begin
            if (r_go_l) begin
                if (r_go_r && 32'(r_sp) < STACK_DEPTH) begin
                    r_stack[r_sp[SA_W-1:0]] <= n_rc[CUR_W-1:0];
                    r_sp <= r_sp + 1'b1;
                end
                r_cur <= n_lc[CUR_W-1:0];
            end else if (r_go_r) begin
                r_cur <= n_rc[CUR_W-1:0];
            end else if (r_sp != '0) begin
                r_cur <= r_stack[SA_W'(r_sp - 1'b1)];
                r_sp  <= r_sp - 1'b1;
            end else begin
                r_done <= 1'b1;
            end
        end
    end

    // Counter memory: one read and one write port, read registered
    logic [CA_W-1:0] n_raddr;
    logic [krpc_pkg::CNT_W:0] n_add;
    always_comb begin
        n_raddr = i_cmd.rd_sel ? CA_W'(32'(r_qf) * TREE_FIELDS + 32'(r_tf)) : r_cell;
        n_add   = {1'b0, r_cnt_rd} + (krpc_pkg::CNT_W+1)'(r_w);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_rd) r_cnt_rd <= r_cnt[n_raddr];
        if (i_cmd.clr) begin
            r_cnt[r_clr[CA_W-1:0]] <= '0;
        end else if (i_cmd.cnt_wr) begin
            r_cnt[r_cell] <= n_add[krpc_pkg::CNT_W] ? CNT_MAX
                                                    : n_add[krpc_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_cell_ok <= (32'(i_query_field) < QUERY_FIELDS)
                                     && (32'(i_tree_field) < TREE_FIELDS);
        if (i_cmd.out_load) r_out <= r_cell_ok ? r_cnt_rd : '0;
    end

    assign o_count_value     = r_out;
    assign o_status.do_count = r_cnt_en;
    assign o_status.walk_done = r_done;
    assign o_status.clr_done = (32'(r_clr) >= CELLS - 1);

endmodule

@@ rtl/krpc_ctrl.sv @@
// Controller state machine sequencing loads, walks, reads and clears.
// Depends on krpc_pkg.
module krpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_mode,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  krpc_pkg::t_status i_status,
    output krpc_pkg::t_cmd    o_cmd
);
    krpc_pkg::t_state r_state, n_state;
    logic r_ovalid, n_ovalid;
    logic n_acc;

    assign n_acc = i_valid && (r_state == krpc_pkg::ST_IDLE) && !(r_ovalid && i_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            krpc_pkg::ST_IDLE: begin
                if (n_acc) begin
                    case (i_mode)
                        krpc_pkg::MODE_LOAD:  n_state = krpc_pkg::ST_IDLE;
                        krpc_pkg::MODE_QUERY: n_state = krpc_pkg::ST_FETCH;
                        krpc_pkg::MODE_READ:  n_state = krpc_pkg::ST_READ;
                        default:              n_state = krpc_pkg::ST_CLEAR;
                    endcase
                end
            end
            krpc_pkg::ST_FETCH:
                n_state = i_status.walk_done ? krpc_pkg::ST_IDLE : krpc_pkg::ST_WAIT;
            krpc_pkg::ST_WAIT:   n_state = krpc_pkg::ST_SQ;
            krpc_pkg::ST_SQ:     n_state = krpc_pkg::ST_SUM;
            krpc_pkg::ST_SUM:    n_state = krpc_pkg::ST_DECIDE;
            krpc_pkg::ST_DECIDE:
                n_state = i_status.do_count ? krpc_pkg::ST_CNT_RD : krpc_pkg::ST_FETCH;
            krpc_pkg::ST_CNT_RD: n_state = krpc_pkg::ST_CNT_WR;
            krpc_pkg::ST_CNT_WR: n_state = krpc_pkg::ST_FETCH;
            krpc_pkg::ST_READ:   n_state = krpc_pkg::ST_OUT;
            krpc_pkg::ST_OUT:    n_state = krpc_pkg::ST_IDLE;
            krpc_pkg::ST_CLEAR:
                n_state = i_status.clr_done ? krpc_pkg::ST_IDLE : krpc_pkg::ST_CLEAR;
            default:             n_state = krpc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        n_ovalid = r_ovalid && i_stall;
        case (r_state)
            krpc_pkg::ST_IDLE: begin
                o_cmd.capture   = n_acc;
                o_cmd.load_node = n_acc && (i_mode == krpc_pkg::MODE_LOAD);
                o_cmd.clr_start = n_acc;
            end
            krpc_pkg::ST_FETCH:  o_cmd.fetch  = !i_status.walk_done;
            krpc_pkg::ST_SQ:     o_cmd.square = 1'b1;
            krpc_pkg::ST_SUM:    o_cmd.sum    = 1'b1;
            krpc_pkg::ST_DECIDE: begin
                o_cmd.step   = 1'b1;
                o_cmd.cnt_rd = i_status.do_count;
            end
            krpc_pkg::ST_CNT_WR: o_cmd.cnt_wr = 1'b1;
            krpc_pkg::ST_READ: begin
                o_cmd.cnt_rd = 1'b1;
                o_cmd.rd_sel = 1'b1;
            end
            krpc_pkg::ST_OUT: begin
                o_cmd.out_load = 1'b1;
                n_ovalid = 1'b1;
            end
            krpc_pkg::ST_CLEAR:  o_cmd.clr = 1'b1;
            default:             o_cmd = '0;
        endcase
    end

    // Reset enters the clearing pass so every counter cell starts at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= krpc_pkg::ST_CLEAR;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stall = !(r_state == krpc_pkg::ST_IDLE) || (r_ovalid && i_stall);
    assign o_valid = r_ovalid;

endmodule

@@ rtl/kdtree_radius_pair_counter.sv @@
// Top level: kd-tree fixed-radius weighted pair counter.
// A load is written on accept; a read passes the read and output states before o_valid;
// a clear follows the accept, one cell per cycle; a query runs fetch, memory wait, square,
// sum and decide per visited node, counter read and write per counted node, and a final
// fetch. One beat is worked at a time; a result held by i_stall stalls the input.
// Reset (i_rst_n low, synchronous) clears control, the walk and the radius, then clears the
// 64 counter cells one per cycle with the input stalled. Node memories are undefined until
// loaded.
module kdtree_radius_pair_counter #(
    parameter int unsigned DIMS         = krpc_pkg::DIMS_DEF,
    parameter int unsigned NODE_COUNT   = krpc_pkg::NODE_COUNT_DEF,
    parameter int unsigned TREE_FIELDS  = krpc_pkg::TREE_FIELDS_DEF,
    parameter int unsigned QUERY_FIELDS = krpc_pkg::QUERY_FIELDS_DEF,
    parameter int unsigned STACK_DEPTH  = krpc_pkg::STACK_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [krpc_pkg::RAD_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_mode,
    input  logic [krpc_pkg::IDX_W-1:0]          i_node_index,
    input  logic signed [krpc_pkg::COORD_W-1:0] i_coord_0,
    input  logic signed [krpc_pkg::COORD_W-1:0] i_coord_1,
    input  logic signed [krpc_pkg::COORD_W-1:0] i_coord_2,
    input  logic [1:0]                          i_split_axis,
    input  logic                                i_has_left,
    input  logic                                i_has_right,
    input  logic [krpc_pkg::WGT_W-1:0]          i_node_weight,
    input  logic [krpc_pkg::FLD_W-1:0]          i_tree_field,
    input  logic [krpc_pkg::FLD_W-1:0]          i_query_field,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [krpc_pkg::CNT_W-1:0]          o_count_value
);
    krpc_pkg::t_cmd    w_cmd;
    krpc_pkg::t_status w_status;
    logic [krpc_pkg::RAD_W-1:0] r_radius;

    // Hold the radius register; software writes it only while idle; the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_data;
        end
    end

    krpc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    krpc_datapath #(
        .DIMS         (DIMS),
        .NODE_COUNT   (NODE_COUNT),
        .TREE_FIELDS  (TREE_FIELDS),
        .QUERY_FIELDS (QUERY_FIELDS),
        .STACK_DEPTH  (STACK_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_radius      (r_radius),
        .i_node_index  (i_node_index),
        .i_coord_0     (i_coord_0),
        .i_coord_1     (i_coord_1),
        .i_coord_2     (i_coord_2),
        .i_split_axis  (i_split_axis),
        .i_has_left    (i_has_left),
        .i_has_right   (i_has_right),
        .i_node_weight (i_node_weight),
        .i_tree_field  (i_tree_field),
        .i_query_field (i_query_field),
        .o_count_value (o_count_value)
    );

endmodule

@@ bench/tb_kdtree_radius_pair_counter.sv @@
// Testbench for kdtree_radius_pair_counter: loads random kd-trees, runs radius
// queries and reads counter cells, checking each read beat against a local predictor.
// Depends on rtl/krpc_pkg.sv and rtl/kdtree_radius_pair_counter.sv.
module tb_kdtree_radius_pair_counter;

    localparam int unsigned CNT_W   = krpc_pkg::CNT_W;
    localparam int unsigned IDX_W   = krpc_pkg::IDX_W;
    localparam int unsigned COORD_W = krpc_pkg::COORD_W;
    localparam int unsigned WGT_W   = krpc_pkg::WGT_W;
    localparam int unsigned FLD_W   = krpc_pkg::FLD_W;
    localparam int unsigned RAD_W   = krpc_pkg::RAD_W;
    localparam logic [1:0] MODE_LOAD  = krpc_pkg::MODE_LOAD;
    localparam logic [1:0] MODE_QUERY = krpc_pkg::MODE_QUERY;
    localparam logic [1:0] MODE_READ  = krpc_pkg::MODE_READ;
    localparam logic [1:0] MODE_CLEAR = krpc_pkg::MODE_CLEAR;

    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};
    localparam int unsigned NODES = krpc_pkg::NODE_COUNT_DEF;

    typedef struct {
        logic [1:0]               mode;
        logic [IDX_W-1:0]         idx;
        logic signed [COORD_W-1:0] c0, c1, c2;
        logic [1:0]               axis;
        logic                     hl, hr;
        logic [WGT_W-1:0]         w;
        logic [FLD_W-1:0]         tf, qf;
    } t_beat;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [RAD_W-1:0]          i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [1:0]                i_mode = MODE_CLEAR;
    logic [IDX_W-1:0]          i_node_index = '0;
    logic signed [COORD_W-1:0] i_coord_0 = '0, i_coord_1 = '0, i_coord_2 = '0;
    logic [1:0]                i_split_axis = '0;
    logic                      i_has_left = 1'b0, i_has_right = 1'b0;
    logic [WGT_W-1:0]          i_node_weight = '0;
    logic [FLD_W-1:0]          i_tree_field = '0, i_query_field = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [CNT_W-1:0]          o_count_value;

    kdtree_radius_pair_counter u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(i_mode), .i_node_index(i_node_index),
        .i_coord_0(i_coord_0), .i_coord_1(i_coord_1), .i_coord_2(i_coord_2),
        .i_split_axis(i_split_axis), .i_has_left(i_has_left), .i_has_right(i_has_right),
        .i_node_weight(i_node_weight), .i_tree_field(i_tree_field),
        .i_query_field(i_query_field),
        .o_valid(o_valid), .i_stall(i_stall), .o_count_value(o_count_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: node memories, counter table and radius
    logic signed [COORD_W-1:0] node_x [NODES];
    logic signed [COORD_W-1:0] node_y [NODES];
    logic signed [COORD_W-1:0] node_z [NODES];
    logic [1:0]                node_axis [NODES];
    logic                      node_left [NODES];
    logic                      node_right [NODES];
    logic [WGT_W-1:0]          node_wgt [NODES];
    logic [FLD_W-1:0]          node_fld [NODES];
    logic [CNT_W-1:0]          pair_table [8][8];
    logic [RAD_W-1:0]          radius = '0;

    logic [CNT_W-1:0] expected_counts [$];
    int unsigned      tree_nodes [$];   // indices of the tree now loaded

    int  errors = 0;
    int  items_sent = 0;
    int  n_loads = 0, n_queries = 0, n_reads = 0, n_clears = 0, n_hits = 0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;

    // Walk the tree for one query point and add weights into the counter table.
    function automatic void walk_query(input logic signed [COORD_W-1:0] q0, q1, q2,
                                       input logic [FLD_W-1:0] qf);
        longint          rad, pt, v, df;
        longint unsigned rsq, dsq, nxt;
        longint          q [3];
        longint          p [3];
        int unsigned     stk [10];
        int unsigned     sp, cur, lc, rc;
        bit              live, go_l, go_r, cnt;
        rad = longint'(radius);
        rsq = longint'(rad * rad);
        q[0] = longint'(q0); q[1] = longint'(q1); q[2] = longint'(q2);
        sp = 0;
        cur = 1;
        live = 1'b1;
        while (live) begin
            p[0] = longint'(node_x[cur]); p[1] = longint'(node_y[cur]);
            p[2] = longint'(node_z[cur]);
            dsq = 0;
            for (int d = 0; d < 3; d++) begin
                df = p[d] - q[d];
                if (df < 0) df = -df;
                dsq += longint'(df * df);
            end
            lc = 2 * cur;
            rc = 2 * cur + 1;
            go_l = 1'b0; go_r = 1'b0; cnt = 1'b1;
            if (!node_left[cur]) begin
                // leaf, right flag ignored
            end else if (!node_right[cur]) begin
                go_l = 1'b1;
            end else if (node_axis[cur] < 3) begin
                pt = p[node_axis[cur]];
                v = q[node_axis[cur]];
                if (v + rad < pt) begin
                    go_l = 1'b1; cnt = 1'b0;
                end else if (v - rad > pt) begin
                    go_r = 1'b1; cnt = 1'b0;
                end else begin
                    go_l = 1'b1; go_r = 1'b1;
                end
            end else begin
                go_l = 1'b1; go_r = 1'b1;
            end
            if (cnt && dsq < rsq) begin
                nxt = pair_table[qf][node_fld[cur]] + node_wgt[cur];
                pair_table[qf][node_fld[cur]] = (nxt > CNT_SAT) ? CNT_SAT : nxt[CNT_W-1:0];
                n_hits++;
            end
            if (go_l && lc >= NODES) go_l = 1'b0;
            if (go_r && rc >= NODES) go_r = 1'b0;
            if (go_l) begin
                if (go_r && sp < 10) begin
                    stk[sp] = rc;
                    sp++;
                end
                cur = lc;
            end else if (go_r) begin
                cur = rc;
            end else if (sp > 0) begin
                sp--;
                cur = stk[sp];
            end else begin
                live = 1'b0;
            end
        end
    endfunction

    function automatic void apply_beat(input t_beat b);
        case (b.mode)
            MODE_LOAD: begin
                node_x[b.idx] = b.c0; node_y[b.idx] = b.c1; node_z[b.idx] = b.c2;
                node_axis[b.idx] = b.axis;
                node_left[b.idx] = b.hl; node_right[b.idx] = b.hr;
                node_wgt[b.idx] = b.w; node_fld[b.idx] = b.tf;
                n_loads++;
            end
            MODE_QUERY: begin
                walk_query(b.c0, b.c1, b.c2, b.qf);
                n_queries++;
            end
            MODE_READ: begin
                expected_counts.push_back(pair_table[b.qf][b.tf]);
                n_reads++;
            end
            default: begin
                foreach (pair_table[r, c]) pair_table[r][c] = '0;
                n_clears++;
            end
        endcase
    endfunction

    // Present one beat and hold it until accepted; valid stays high for a follow-on beat.
    task automatic send_beat(input t_beat b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= b.mode; i_node_index <= b.idx;
        i_coord_0 <= b.c0; i_coord_1 <= b.c1; i_coord_2 <= b.c2;
        i_split_axis <= b.axis; i_has_left <= b.hl; i_has_right <= b.hr;
        i_node_weight <= b.w; i_tree_field <= b.tf; i_query_field <= b.qf;
        do @(posedge i_clk); while (o_stall);
        apply_beat(b);
        items_sent++;
    endtask

    function automatic t_beat blank_beat(input logic [1:0] m);
        t_beat b;
        b.mode = m; b.idx = IDX_W'($urandom);
        b.c0 = COORD_W'($urandom); b.c1 = COORD_W'($urandom); b.c2 = COORD_W'($urandom);
        b.axis = 2'($urandom); b.hl = 1'($urandom); b.hr = 1'($urandom);
        b.w = WGT_W'($urandom);
        b.tf = FLD_W'($urandom); b.qf = FLD_W'($urandom);
        return b;
    endfunction

    // Coordinate near a center; span 0 means anywhere in the full range.
    function automatic logic signed [COORD_W-1:0] near(input logic signed [COORD_W-1:0] ctr,
                                                       input int span);
        if (span == 0) return COORD_W'($urandom);
        return ctr + COORD_W'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic send_read(input logic [FLD_W-1:0] qf, tf);
        t_beat b;
        b = blank_beat(MODE_READ);
        b.qf = qf; b.tf = tf;
        send_beat(b);
    endtask

    task automatic send_query_near(input int span);
        t_beat b;
        int unsigned k;
        b = blank_beat(MODE_QUERY);
        k = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
        b.c0 = near(node_x[k], span); b.c1 = near(node_y[k], span);
        b.c2 = near(node_z[k], span);
        send_beat(b);
    endtask

    // Drop valid, let the block drain, then write the radius.
    task automatic write_radius(input logic [RAD_W-1:0] r);
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (expected_counts.size() == 0);
        repeat (8 * tree_nodes.size() + 100) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= r;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        radius = r;
    endtask

    // Load a tree breadth first; every flagged child in range is loaded too.
    task automatic build_tree(input int budget, input int span);
        int unsigned frontier [$];
        int unsigned p;
        int used;
        int kind;
        logic signed [COORD_W-1:0] ctr0, ctr1, ctr2;
        t_beat b;
        ctr0 = COORD_W'($urandom); ctr1 = COORD_W'($urandom); ctr2 = COORD_W'($urandom);
        tree_nodes.delete();
        frontier.push_back(1);
        used = 1;
        while (frontier.size() > 0) begin
            p = frontier.pop_front();
            tree_nodes.push_back(p);
            b = blank_beat(MODE_LOAD);
            b.idx = IDX_W'(p);
            b.c0 = near(ctr0, span); b.c1 = near(ctr1, span); b.c2 = near(ctr2, span);
            kind = (p >= NODES / 2 || used + 2 > budget) ? 0 : $urandom_range(0, 4);
            if (p >= NODES / 2) begin
                // children fall outside the memory, so any flags are safe
            end else if (kind == 0) begin
                b.hl = 1'b0;
            end else if (kind == 1) begin
                b.hl = 1'b1; b.hr = 1'b0;
                frontier.push_back(2 * p);
                used++;
            end else begin
                b.hl = 1'b1; b.hr = 1'b1;
                frontier.push_back(2 * p);
                frontier.push_back(2 * p + 1);
                used += 2;
            end
            send_beat(b);
        end
    endtask

    // Result side: check each accepted beat, then choose next cycle's stall.
    int hold_left = 0;
    int burst_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_counts.size() == 0) begin
                    $display("%0t: count beat %h with nothing expected", $time, o_count_value);
                    errors++;
                end else if (o_count_value !== expected_counts[0]) begin
                    $display("%0t: count mismatch expected %h actual %h",
                             $time, expected_counts[0], o_count_value);
                    errors++;
                    void'(expected_counts.pop_front());
                end else begin
                    void'(expected_counts.pop_front());
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(0, 4);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Reads straight after reset see cleared counters; then clear and read again.
    task automatic test_clear_and_empty();
        send_read(3'd0, 3'd0);
        send_read(3'd7, 3'd7);
        send_beat(blank_beat(MODE_CLEAR));
        send_read(3'd0, 3'd0);
        send_read(3'd7, 3'd7);
    endtask

    // Left-only chain from the root down to the deepest row, whose children are out
    // of range; radius at its maximum so every node is within reach.
    task automatic test_deep_chain();
        t_beat b;
        write_radius({RAD_W{1'b1}});
        tree_nodes.delete();
        for (int unsigned p = 1; p < NODES; p = 2 * p) begin
            b = blank_beat(MODE_LOAD);
            b.idx = IDX_W'(p);
            b.c0 = COORD_W'(p * 3); b.c1 = -COORD_W'(p); b.c2 = '0;
            b.hl = 1'b1; b.hr = (p >= NODES / 2);
            b.w = (p == 1) ? {WGT_W{1'b1}} : WGT_W'(p);
            b.tf = FLD_W'(p % 8);
            tree_nodes.push_back(p);
            send_beat(b);
        end
        b = blank_beat(MODE_LOAD);
        b.idx = '0;   // node 0 is stored but never visited
        send_beat(b);
        b = blank_beat(MODE_QUERY);
        b.c0 = '0; b.c1 = '0; b.c2 = '0; b.qf = 3'd5;
        send_beat(b);
        send_read(3'd5, 3'd1);
        send_read(3'd5, 3'd0);
    endtask

    // Root with both children: pruning left, pruning right, no-prune axis, zero radius.
    task automatic test_pruning();
        t_beat b;
        tree_nodes = {1, 2, 3};
        for (int unsigned p = 1; p <= 3; p++) begin
            b = blank_beat(MODE_LOAD);
            b.idx = IDX_W'(p);
            b.c0 = (p == 1) ? '0 : (p == 2) ? -COORD_W'(32'h10000) : COORD_W'(32'h10000);
            b.c1 = '0; b.c2 = '0;
            b.axis = 2'd0; b.hl = (p == 1); b.hr = 1'b1;
            b.w = 16'd7; b.tf = 3'd2;
            send_beat(b);
        end
        write_radius(RAD_W'(32'h8000));
        for (int k = 0; k < 3; k++) begin
            b = blank_beat(MODE_QUERY);
            b.c0 = (k == 0) ? -COORD_W'(32'h10000) : (k == 1) ? COORD_W'(32'h10000) : '0;
            b.c1 = '0; b.c2 = '0; b.qf = 3'd1;
            send_beat(b);
        end
        b = blank_beat(MODE_LOAD);
        b.idx = IDX_W'(1); b.c0 = '0; b.c1 = '0; b.c2 = '0;
        b.axis = 2'd3; b.hl = 1'b1; b.hr = 1'b1; b.w = 16'd1; b.tf = 3'd2;
        send_beat(b);
        b = blank_beat(MODE_QUERY);
        b.c0 = COORD_W'(32'h10000); b.c1 = '0; b.c2 = '0; b.qf = 3'd1;
        send_beat(b);
        send_read(3'd1, 3'd2);
        write_radius('0);
        send_beat(b);
        send_read(3'd1, 3'd2);
    endtask

    // Random trees and mixed traffic; radius rewritten between rounds.
    task automatic test_random_traffic(input int target);
        int span;
        int r;
        t_beat b;
        while (items_sent < target) begin
            r = $urandom_range(0, 9);
            case ($urandom_range(0, 3))
                0: span = 256;
                1: span = 65536;
                2: span = 2000000;
                default: span = 0;
            endcase
            if (r == 0) write_radius('0);
            else if (r == 1) write_radius({RAD_W{1'b1}});
            else write_radius(RAD_W'($urandom_range(0, span == 0 ? 8388607 : 2 * span)));
            build_tree($urandom_range(0, 7) == 0 ? 60 : $urandom_range(1, 15), span);
            repeat ($urandom_range(10, 30)) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    send_query_near(span == 0 ? 0 : $urandom_range(0, 2 * span));
                end else if (r < 80) begin
                    send_read(FLD_W'($urandom), FLD_W'($urandom));
                end else if (r < 92) begin
                    // rewrite data of a tree node, keeping its child flags
                    b = blank_beat(MODE_LOAD);
                    b.idx = IDX_W'(tree_nodes[$urandom_range(0, tree_nodes.size() - 1)]);
                    b.hl = node_left[b.idx]; b.hr = node_right[b.idx];
                    send_beat(b);
                end else if (r < 96) begin
                    send_beat(blank_beat(MODE_CLEAR));
                end else begin
                    b = blank_beat(MODE_LOAD);
                    b.idx = '0;
                    send_beat(b);
                end
            end
        end
    endtask

    // Hold the result side off while reads keep coming, so the block backs up.
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (20) send_read(FLD_W'($urandom), FLD_W'($urandom));
    endtask

    initial begin
        foreach (pair_table[r, c]) pair_table[r][c] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_clear_and_empty();
        test_deep_chain();
        test_pruning();
        test_random_traffic(400);
        test_backpressure();
        test_random_traffic(520);
        idle_on = 1'b0;
        test_random_traffic(600);
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (expected_counts.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d loads, %0d queries (%0d in-radius hits), %0d reads, %0d clears",
                 n_loads, n_queries, n_hits, n_reads, n_clears);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("FAILURE");
        $finish;
    end

endmodule
